FILE: rtl/sam_pkg.sv
// shared types and constants of the spi adc master
`default_nettype none

package sam_pkg;

   localparam int MAX_TX_BYTES_DEF = 4;
   localparam int MAX_RX_BYTES_DEF = 4;
   localparam int RESET_BYTES_DEF  = 9;

   localparam int CONV_GAP_TICKS = 10;
   localparam int GAP_W          = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // result word layout
   localparam int RSP_CS_N_BIT  = 0;
   localparam int RSP_SCLK_BIT  = 1;
   localparam int RSP_MOSI_BIT  = 2;
   localparam int RSP_BUSY_BIT  = 3;
   localparam int RSP_VALID_BIT = 4;
   localparam int RSP_WORD_LSB  = 5;
   localparam int RSP_INDEX_LSB = 37;
   localparam int RSP_DONE_BIT  = 53;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_TX_COUNT    = 3'd1,
      CSR_TX_BYTES    = 3'd2,
      CSR_RX_COUNT    = 3'd3,
      CSR_CONVERSIONS = 3'd4
   } csr_addr_type;

   typedef enum logic [1:0] {
      MODE_RESET  = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_SINGLE = 2'd2,
      MODE_CONT   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_TX    = 4'd1,
      PH_TXGAP = 4'd2,
      PH_RX    = 4'd3,
      PH_RXGAP = 4'd4,
      PH_WHI   = 4'd5,
      PH_WLO   = 4'd6,
      PH_CGAP  = 4'd7,
      PH_END   = 4'd8
   } phase_type;

endpackage

`default_nettype wire

FILE: rtl/spi_adc_master_unit.sv
// spi adc master: half-bit tick sequencer with registered result word
// result: the result word of an accepted tick is registered and shows on rsp_tdata in the next cycle
// throughput: one tick per clock while the downstream side keeps taking results; the output
// register frees itself in the cycle the downstream side takes the pending result
// reset: synchronous, clears the sequencer to idle with cs high, clock high,
// mosi low, and loads the register defaults
`default_nettype none

module spi_adc_master_unit
   import sam_pkg::*;
#(
   parameter int MAX_TX_BYTES = MAX_TX_BYTES_DEF,
   parameter int MAX_RX_BYTES = MAX_RX_BYTES_DEF,
   parameter int RESET_BYTES  = RESET_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // miso, zero fill
   input  wire logic                  req_tuser,  // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // cs_n, sclk, mosi, busy_res, word_valid, rx_word, word_index, done_res, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BYTE_W = $clog2(RESET_BYTES);
   localparam int CMP_W  = BYTE_W + 1;
   localparam int TX_CAP = (MAX_TX_BYTES < 4) ? MAX_TX_BYTES : 4;

   // configuration registers
   mode_type     mode_ff;
   logic [2:0]   tx_count_ff;
   logic [31:0]  tx_bytes_ff;
   logic [2:0]   rx_count_ff;
   logic [15:0]  conversions_ff;

   // sequencer state
   phase_type         phase_ff, phase_in;
   mode_type          run_mode_ff, run_mode_in;
   logic [BYTE_W-1:0] byte_idx_ff, byte_idx_in;
   logic [2:0]        bit_cnt_ff, bit_cnt_in;
   logic              half_ff, half_in;
   logic [31:0]       tx_shift_ff, tx_shift_in;
   logic [31:0]       rx_shift_ff, rx_shift_in;
   logic [15:0]       conv_cnt_ff, conv_cnt_in;
   logic [GAP_W-1:0]  gap_cnt_ff, gap_cnt_in;
   logic              cs_ff, cs_in;
   logic              clk_ff, clk_in;
   logic              mosi_ff, mosi_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic        req_fire;
   logic        cmd, miso;
   logic        word_valid;
   logic [31:0] word;
   logic [15:0] word_index;
   logic        done;

   mode_type         sel_mode;
   logic [2:0]       tx_cnt_sat;
   logic [CMP_W-1:0] tx_len;
   logic [CMP_W-1:0] rx_len;
   logic [CMP_W-1:0] byte_next;
   logic [31:0]      tx_load;
   logic [15:0]      conv_eff;
   logic [16:0]      conv_next;

   assign cmd  = req_tuser;
   assign miso = req_tdata[0];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_RESET;
         tx_count_ff    <= 3'd1;
         tx_bytes_ff    <= '0;
         rx_count_ff    <= 3'd3;
         conversions_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE:        mode_ff        <= mode_type'(csr_wdata[1:0]);
            CSR_TX_COUNT:    tx_count_ff    <= csr_wdata[2:0];
            CSR_TX_BYTES:    tx_bytes_ff    <= csr_wdata[31:0];
            CSR_RX_COUNT:    rx_count_ff    <= csr_wdata[2:0];
            CSR_CONVERSIONS: conversions_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // lengths read the live registers, the mode is latched at start
   assign sel_mode   = (phase_ff == PH_IDLE) ? mode_ff : run_mode_ff;
   assign tx_cnt_sat = (tx_count_ff > 3'(TX_CAP)) ? 3'(TX_CAP) : tx_count_ff;
   assign tx_len     = (sel_mode == MODE_RESET) ? CMP_W'(RESET_BYTES) : CMP_W'(tx_cnt_sat);
   assign rx_len     = (rx_count_ff == 3'd0) ? CMP_W'(1) :
                       (rx_count_ff > 3'(MAX_RX_BYTES)) ? CMP_W'(MAX_RX_BYTES) :
                       CMP_W'(rx_count_ff);
   assign byte_next  = CMP_W'(byte_idx_ff) + CMP_W'(1);
   assign conv_eff   = (conversions_ff == 16'd0) ? 16'd1 : conversions_ff;
   assign conv_next  = {1'b0, conv_cnt_ff} + 17'd1;

   always_comb begin
      case (tx_cnt_sat)
         3'd1:    tx_load = tx_bytes_ff << 24;
         3'd2:    tx_load = tx_bytes_ff << 16;
         3'd3:    tx_load = tx_bytes_ff << 8;
         default: tx_load = tx_bytes_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         run_mode_ff <= MODE_RESET;
         byte_idx_ff <= '0;
         bit_cnt_ff  <= '0;
         half_ff     <= 1'b0;
         tx_shift_ff <= '0;
         rx_shift_ff <= '0;
         conv_cnt_ff <= '0;
         gap_cnt_ff  <= '0;
         cs_ff       <= 1'b1;
         clk_ff      <= 1'b1;
         mosi_ff     <= 1'b0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         run_mode_ff <= run_mode_in;
         byte_idx_ff <= byte_idx_in;
         bit_cnt_ff  <= bit_cnt_in;
         half_ff     <= half_in;
         tx_shift_ff <= tx_shift_in;
         rx_shift_ff <= rx_shift_in;
         conv_cnt_ff <= conv_cnt_in;
         gap_cnt_ff  <= gap_cnt_in;
         cs_ff       <= cs_in;
         clk_ff      <= clk_in;
         mosi_ff     <= mosi_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      run_mode_in = run_mode_ff;
      byte_idx_in = byte_idx_ff;
      bit_cnt_in  = bit_cnt_ff;
      half_in     = half_ff;
      tx_shift_in = tx_shift_ff;
      rx_shift_in = rx_shift_ff;
      conv_cnt_in = conv_cnt_ff;
      gap_cnt_in  = gap_cnt_ff;
      cs_in       = cs_ff;
      clk_in      = clk_ff;
      mosi_in     = mosi_ff;
      word_valid  = 1'b0;
      word        = '0;
      word_index  = '0;
      done        = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (cmd) begin
               run_mode_in = mode_ff;
               cs_in       = 1'b0;
               conv_cnt_in = '0;
               if (mode_ff != MODE_WRITE) mosi_in = 1'b1;
               if (mode_ff == MODE_SINGLE) clk_in = 1'b0;
               if (mode_ff == MODE_CONT) begin
                  phase_in = PH_WHI;
               end else begin
                  byte_idx_in = '0;
                  bit_cnt_in  = '0;
                  half_in     = 1'b0;
                  if (tx_len == '0) begin
                     if (mode_ff == MODE_SINGLE) begin
                        rx_shift_in = '0;
                        phase_in    = PH_RX;
                     end else begin
                        phase_in = PH_END;
                     end
                  end else begin
                     if (mode_ff != MODE_RESET) tx_shift_in = tx_load;
                     phase_in = PH_TX;
                  end
               end
            end
         end
         PH_TX: begin
            if (!half_ff) begin
               clk_in  = 1'b0;
               mosi_in = (run_mode_ff == MODE_RESET) ? 1'b1 : tx_shift_ff[31];
               half_in = 1'b1;
            end else begin
               clk_in      = 1'b1;
               tx_shift_in = {tx_shift_ff[30:0], 1'b0};
               half_in     = 1'b0;
               if (bit_cnt_ff == 3'd7) begin
                  bit_cnt_in = '0;
                  phase_in   = PH_TXGAP;
               end else begin
                  bit_cnt_in = bit_cnt_ff + 3'd1;
               end
            end
         end
         PH_TXGAP: begin
            clk_in = 1'b1;
            if (byte_next >= tx_len) begin
               if (run_mode_ff == MODE_SINGLE || run_mode_ff == MODE_CONT) begin
                  byte_idx_in = '0;
                  bit_cnt_in  = '0;
                  half_in     = 1'b0;
                  rx_shift_in = '0;
                  phase_in    = PH_RX;
               end else begin
                  phase_in = PH_END;
               end
            end else begin
               byte_idx_in = byte_next[BYTE_W-1:0];
               phase_in    = PH_TX;
            end
         end
         PH_RX: begin
            mosi_in = (run_mode_ff == MODE_CONT);
            if (!half_ff) begin
               clk_in  = 1'b0;
               half_in = 1'b1;
            end else begin
               clk_in      = 1'b1;
               rx_shift_in = {rx_shift_ff[30:0], miso};
               half_in     = 1'b0;
               if (bit_cnt_ff == 3'd7) begin
                  bit_cnt_in = '0;
                  phase_in   = PH_RXGAP;
               end else begin
                  bit_cnt_in = bit_cnt_ff + 3'd1;
               end
            end
         end
         PH_RXGAP: begin
            clk_in = 1'b1;
            if (byte_next >= rx_len) begin
               word_valid = 1'b1;
               word       = rx_shift_ff;
               word_index = conv_cnt_ff;
               if (run_mode_ff == MODE_CONT) begin
                  gap_cnt_in = '0;
                  phase_in   = PH_CGAP;
               end else begin
                  phase_in = PH_END;
               end
            end else begin
               byte_idx_in = byte_next[BYTE_W-1:0];
               phase_in    = PH_RX;
            end
         end
         PH_CGAP: begin
            if ({1'b0, gap_cnt_ff} + (GAP_W+1)'(1) >= (GAP_W+1)'(CONV_GAP_TICKS)) begin
               gap_cnt_in = '0;
               if (conv_next >= {1'b0, conv_eff}) begin
                  phase_in = PH_END;
               end else begin
                  conv_cnt_in = conv_next[15:0];
                  phase_in    = PH_WHI;
               end
            end else begin
               gap_cnt_in = gap_cnt_ff + GAP_W'(1);
            end
         end
         PH_WHI: begin
            if (miso) phase_in = PH_WLO;
         end
         PH_WLO: begin
            if (!miso) begin
               byte_idx_in = '0;
               bit_cnt_in  = '0;
               half_in     = 1'b0;
               if (tx_len == '0) begin
                  rx_shift_in = '0;
                  phase_in    = PH_RX;
               end else begin
                  tx_shift_in = tx_load;
                  phase_in    = PH_TX;
               end
            end
         end
         default: begin
            cs_in    = 1'b1;
            clk_in   = 1'b1;
            mosi_in  = 1'b0;
            done     = 1'b1;
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {2'b00, done, word_index, word, word_valid,
                         (phase_in != PH_IDLE), mosi_in, clk_in, cs_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cs_low_when_busy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> !cs_ff)
      else $error("chip select high during a transaction");

   a_half_in_shift: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (phase_ff == PH_TX || phase_ff == PH_RX))
      else $error("half bit flag set outside a shift phase");

   a_hold_without_tick: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(phase_ff) && $stable(conv_cnt_ff))
      else $error("sequencer moved without an accepted tick");

   a_word_then_gap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && word_valid) |=> (phase_ff == PH_CGAP || phase_ff == PH_END))
      else $error("reading delivered outside the last reply gap");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench of the spi adc master: directed frames, then random frames
`timescale 1ns / 1ps

module testbench;
   import sam_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  fill;
      logic        done_res;
      logic [15:0] word_index;
      logic [31:0] rx_word;
      logic        word_valid;
      logic        busy_res;
      logic        mosi;
      logic        sclk;
      logic        cs_n;
   } tick_result_type;

   // pins on the first tick of the case, from the top: cs_n, sclk, mosi, busy
   typedef struct packed {
      bit           start;
      bit           write_cfg;
      mode_type     mode;
      logic [2:0]   tx_count;
      logic [31:0]  tx_bytes;
      logic [2:0]   rx_count;
      logic [15:0]  conversions;
      logic [15:0]  cut_at;
      csr_addr_type cut_reg;
      logic [31:0]  cut_val;
      bit           typed;
      logic [3:0]   pins;
   } frame_case_type;

   localparam frame_case_type FRAME_CASES[15] = '{
      '{1'b0, 1'b0, MODE_RESET,  3'd0, 32'h0000_0000, 3'd0, 16'd0,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b1100},
      '{1'b1, 1'b0, MODE_RESET,  3'd0, 32'h0000_0000, 3'd0, 16'd0,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b0111},
      '{1'b1, 1'b1, MODE_WRITE,  3'd0, 32'h0000_0000, 3'd3, 16'd1,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b0101},
      '{1'b1, 1'b1, MODE_WRITE,  3'd4, 32'hFFFF_FFFF, 3'd3, 16'd1,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b0101},
      '{1'b1, 1'b1, MODE_WRITE,  3'd7, 32'hA5C3_0F5A, 3'd3, 16'd1,     16'd0,
        CSR_MODE, 32'd0, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_WRITE,  3'd2, 32'h0000_0081, 3'd3, 16'd1,     16'd20,
        CSR_TX_COUNT, 32'd1, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_SINGLE, 3'd0, 32'h0000_0000, 3'd0, 16'd1,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b0011},
      '{1'b1, 1'b1, MODE_SINGLE, 3'd4, 32'h1234_5678, 3'd4, 16'd1,     16'd0,
        CSR_MODE, 32'd0, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_SINGLE, 3'd1, 32'h0000_0080, 3'd7, 16'd1,     16'd0,
        CSR_MODE, 32'd0, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_SINGLE, 3'd3, 32'h00FF_00FF, 3'd3, 16'd1,     16'd75,
        CSR_RX_COUNT, 32'd1, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_CONT,   3'd1, 32'h0000_0001, 3'd3, 16'd0,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b0111},
      '{1'b1, 1'b1, MODE_CONT,   3'd0, 32'h0000_0000, 3'd4, 16'd3,     16'd0,
        CSR_MODE, 32'd0, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_CONT,   3'd2, 32'h0000_F00F, 3'd1, 16'hFFFF,  16'd200,
        CSR_CONVERSIONS, 32'd1, 1'b0, 4'b0000},
      '{1'b1, 1'b1, MODE_RESET,  3'd0, 32'h0000_0000, 3'd0, 16'd0,     16'd0,
        CSR_MODE, 32'd0, 1'b1, 4'b0111},
      '{1'b1, 1'b1, MODE_WRITE,  3'd3, 32'h00AB_CDEF, 3'd2, 16'd1,     16'd30,
        CSR_MODE, 32'd3, 1'b0, 4'b0000}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   spi_adc_master_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // register copies
   mode_type    mode_q     = MODE_RESET;
   logic [2:0]  tx_count_q = 3'd1;
   logic [31:0] tx_bytes_q = '0;
   logic [2:0]  rx_count_q = 3'd3;
   logic [15:0] conv_q     = 16'd1;

   // sequencer copy
   phase_type   phase      = PH_IDLE;
   mode_type    run_mode   = MODE_RESET;
   logic [3:0]  byte_idx   = '0;
   logic [2:0]  bit_cnt    = '0;
   logic        half       = 1'b0;
   logic [31:0] tx_sh      = '0;
   logic [31:0] rx_sh      = '0;
   logic [15:0] conv_cnt   = '0;
   logic [3:0]  gap_cnt    = '0;
   logic        cs_level   = 1'b1;
   logic        sclk_level = 1'b1;
   logic        mosi_level = 1'b0;

   tick_result_type expected_ticks[$];
   tick_result_type got, want;
   int  errors = 0;
   int  ticks_sent = 0;
   int  frames_done = 0;
   int  readings_checked = 0;
   int  live_writes = 0;
   int  stall_cycles = 0;
   bit  steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int command_length();
      int n;
      if (run_mode == MODE_RESET) return RESET_BYTES_DEF;
      n = tx_count_q;
      if (n > MAX_TX_BYTES_DEF) n = MAX_TX_BYTES_DEF;
      if (n > 4) n = 4;
      return n;
   endfunction

   function automatic void start_reply();
      if (run_mode == MODE_RESET || run_mode == MODE_WRITE) begin
         phase = PH_END;
         return;
      end
      byte_idx = '0;
      bit_cnt  = '0;
      half     = 1'b0;
      rx_sh    = '0;
      phase    = PH_RX;
   endfunction

   function automatic void start_command();
      int n;
      n = command_length();
      byte_idx = '0;
      bit_cnt  = '0;
      half     = 1'b0;
      if (n == 0) begin
         start_reply();
         return;
      end
      if (run_mode != MODE_RESET) tx_sh = tx_bytes_q << (32 - 8 * n);
      phase = PH_TX;
   endfunction

   function automatic tick_result_type advance_sequencer(input logic cmd, input logic miso);
      tick_result_type r;
      int limit;
      r = '0;
      case (phase)
         PH_IDLE: begin
            if (cmd) begin
               run_mode = mode_q;
               cs_level = 1'b0;
               if (run_mode != MODE_WRITE) mosi_level = 1'b1;
               if (run_mode == MODE_SINGLE) sclk_level = 1'b0;
               conv_cnt = '0;
               if (run_mode == MODE_CONT) phase = PH_WHI;
               else start_command();
            end
         end
         PH_TX: begin
            if (!half) begin
               sclk_level = 1'b0;
               mosi_level = (run_mode == MODE_RESET) ? 1'b1 : tx_sh[31];
               half = 1'b1;
            end else begin
               sclk_level = 1'b1;
               tx_sh = tx_sh << 1;
               half = 1'b0;
               if (bit_cnt == 3'd7) begin
                  bit_cnt = '0;
                  phase = PH_TXGAP;
               end else begin
                  bit_cnt++;
               end
            end
         end
         PH_TXGAP: begin
            sclk_level = 1'b1;
            if (int'(byte_idx) + 1 >= command_length()) start_reply();
            else begin
               byte_idx++;
               phase = PH_TX;
            end
         end
         PH_RX: begin
            mosi_level = (run_mode == MODE_CONT);
            if (!half) begin
               sclk_level = 1'b0;
               half = 1'b1;
            end else begin
               sclk_level = 1'b1;
               rx_sh = {rx_sh[30:0], miso};
               half = 1'b0;
               if (bit_cnt == 3'd7) begin
                  bit_cnt = '0;
                  phase = PH_RXGAP;
               end else begin
                  bit_cnt++;
               end
            end
         end
         PH_RXGAP: begin
            sclk_level = 1'b1;
            limit = (rx_count_q == 0) ? 1 : int'(rx_count_q);
            if (limit > MAX_RX_BYTES_DEF) limit = MAX_RX_BYTES_DEF;
            if (int'(byte_idx) + 1 >= limit) begin
               r.word_valid = 1'b1;
               r.rx_word = rx_sh;
               r.word_index = conv_cnt;
               if (run_mode == MODE_CONT) begin
                  gap_cnt = '0;
                  phase = PH_CGAP;
               end else begin
                  phase = PH_END;
               end
            end else begin
               byte_idx++;
               phase = PH_RX;
            end
         end
         PH_CGAP: begin
            if (int'(gap_cnt) + 1 >= CONV_GAP_TICKS) begin
               gap_cnt = '0;
               limit = (conv_q == 0) ? 1 : int'(conv_q);
               if (int'(conv_cnt) + 1 >= limit) phase = PH_END;
               else begin
                  conv_cnt++;
                  phase = PH_WHI;
               end
            end else begin
               gap_cnt++;
            end
         end
         PH_WHI: begin
            if (miso) phase = PH_WLO;
         end
         PH_WLO: begin
            if (!miso) start_command();
         end
         default: begin
            cs_level = 1'b1;
            sclk_level = 1'b1;
            mosi_level = 1'b0;
            r.done_res = 1'b1;
            phase = PH_IDLE;
         end
      endcase
      r.cs_n = cs_level;
      r.sclk = sclk_level;
      r.mosi = mosi_level;
      r.busy_res = (phase != PH_IDLE);
      return r;
   endfunction

   task automatic send_tick(input logic cmd, input logic miso, input bit typed,
                            input logic [3:0] pins);
      tick_result_type predicted;
      while (!steady && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, miso};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_sequencer(cmd, miso);
      if (typed) begin
         predicted = '0;
         {predicted.cs_n, predicted.sclk, predicted.mosi, predicted.busy_res} = pins;
      end
      expected_ticks.push_back(predicted);
      ticks_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_register(input csr_addr_type addr, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         CSR_MODE:        mode_q = mode_type'(value[1:0]);
         CSR_TX_COUNT:    tx_count_q = value[2:0];
         CSR_TX_BYTES:    tx_bytes_q = value;
         CSR_RX_COUNT:    rx_count_q = value[2:0];
         CSR_CONVERSIONS: conv_q = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(input mode_type m, input logic [2:0] txn, input logic [31:0] txb,
                            input logic [2:0] rxn, input logic [15:0] conv);
      drain();
      write_register(CSR_MODE, {30'd0, m});
      write_register(CSR_TX_COUNT, {29'd0, txn});
      write_register(CSR_TX_BYTES, txb);
      write_register(CSR_RX_COUNT, {29'd0, rxn});
      write_register(CSR_CONVERSIONS, {16'd0, conv});
      csr_we <= 1'b0;
   endtask

   // one spi frame from the start tick to the tick where cs rises again
   task automatic run_frame(input int cut_at, input csr_addr_type cut_reg,
                            input logic [31:0] cut_val, input bit typed,
                            input logic [3:0] pins);
      int n;
      send_tick(1'b1, 1'($urandom_range(1)), typed, pins);
      n = 0;
      while (phase != PH_IDLE) begin
         n++;
         if (n == cut_at) begin
            drain();
            write_register(cut_reg, cut_val);
            csr_we <= 1'b0;
            live_writes++;
         end
         send_tick($urandom_range(15) == 0, 1'($urandom_range(1)), 1'b0, 4'b0000);
      end
      frames_done++;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 23);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tick_result_type'(rsp_tdata);
         if (expected_ticks.size() == 0) begin
            $display("%0t unexpected result transaction: expected none, actual %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("cs_n", want.cs_n, got.cs_n);
            check_field("sclk", want.sclk, got.sclk);
            check_field("mosi", want.mosi, got.mosi);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("word_valid", want.word_valid, got.word_valid);
            check_field("rx_word", want.rx_word, got.rx_word);
            check_field("word_index", want.word_index, got.word_index);
            check_field("done_res", want.done_res, got.done_res);
            check_field("fill", want.fill, got.fill);
            if (want.word_valid) readings_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t no transaction accepted for %0d cycles", $time, stall_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      frame_case_type fc;
      mode_type       mode_pick;
      logic [15:0]    conv_pick;
      int             cut_at;
      csr_addr_type   cut_reg;
      logic [31:0]    cut_val;
      int             first_tick;
      int             random_frames;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (FRAME_CASES[i]) begin
         fc = FRAME_CASES[i];
         if (fc.write_cfg)
            configure(fc.mode, fc.tx_count, fc.tx_bytes, fc.rx_count, fc.conversions);
         if (fc.start) run_frame(fc.cut_at, fc.cut_reg, fc.cut_val, fc.typed, fc.pins);
         else send_tick(1'b0, 1'($urandom_range(1)), fc.typed, fc.pins);
      end

      first_tick = ticks_sent;
      random_frames = 0;
      while (ticks_sent - first_tick < 600) begin
         steady = (ticks_sent - first_tick < 150);
         mode_pick = mode_type'($urandom_range(3));
         if (mode_pick == MODE_RESET && $urandom_range(3) != 0)
            mode_pick = mode_type'($urandom_range(3, 1));
         conv_pick = 16'($urandom_range(4));
         cut_at = 0;
         cut_reg = CSR_MODE;
         cut_val = '0;
         if (conv_pick == 0 && $urandom_range(2) == 0) begin
            conv_pick = 16'hFFFF;
            cut_at = $urandom_range(400, 100);
            cut_reg = CSR_CONVERSIONS;
            cut_val = $urandom_range(2);
         end else if ($urandom_range(5) == 0) begin
            cut_at = $urandom_range(80, 5);
            cut_reg = csr_addr_type'($urandom_range(3));
            cut_val = (cut_reg == CSR_TX_BYTES) ? $urandom : $urandom_range(7);
         end
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(5, 1)) send_tick(1'b0, 1'($urandom_range(1)), 1'b0, 4'b0000);
         configure(mode_pick, 3'($urandom_range(7)), $urandom, 3'($urandom_range(7)),
                   conv_pick);
         run_frame(cut_at, cut_reg, cut_val, 1'b0, 4'b0000);
         random_frames++;
      end
      steady = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      $display("%0d ticks over %0d spi frames in all four modes, %0d readings checked",
               ticks_sent, frames_done, readings_checked);
      $display("%0d register changes made mid-frame, %0d mismatches", live_writes, errors);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
